// ===== hw/rtl/playfair_digraph_decrypt_macros.svh =====
// Assertion helpers for the digraph decryptor.
`ifndef PLAYFAIR_DIGRAPH_DECRYPT_MACROS_SVH
`define PLAYFAIR_DIGRAPH_DECRYPT_MACROS_SVH

`ifndef SYNTH
`define PFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define PFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/pfd_pkg.sv =====
`default_nettype none

package pfd_pkg;

	localparam int NUM_CELLS   = 25;
	localparam int NUM_LETTERS = 26;
	localparam int SQ_DIM      = 5;

	localparam logic [1:0] OP_CLEAR    = 2'd0;
	localparam logic [1:0] OP_KEY      = 2'd1;
	localparam logic [1:0] OP_KEY_DONE = 2'd2;
	localparam logic [1:0] OP_DECRYPT  = 2'd3;

	localparam logic [7:0] UC_A = 8'h41;
	localparam logic [7:0] UC_Z = 8'h5A;
	localparam logic [7:0] LC_A = 8'h61;
	localparam logic [7:0] LC_Z = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'h20;

	localparam logic [4:0] IDX_I    = 5'd8;
	localparam logic [4:0] IDX_J    = 5'd9;
	localparam logic [4:0] IDX_LAST = 5'd25;
	localparam logic [4:0] CELL_MAX = 5'd25;

	typedef struct packed {
		logic       ok;
		logic [4:0] idx;
	} ltr_idx_t;

	typedef struct packed {
		logic [2:0] row;
		logic [2:0] col;
	} rc_t;

	// key character: folds lower case and J
	function automatic ltr_idx_t key_index(input logic [7:0] ch);
		ltr_idx_t r;
		logic [7:0] up;
		r.ok = 1'b0;
		r.idx = '0;
		up = ch;
		if (ch inside {[LC_A:LC_Z]})
			up = ch - CASE_GAP;
		if (up inside {[UC_A:UC_Z]}) begin
			r.ok = 1'b1;
			r.idx = 5'(up - UC_A);
			if (r.idx == IDX_J)
				r.idx = IDX_I;
		end
		return r;
	endfunction

	// ciphertext character: upper case only, J taken as I
	function automatic ltr_idx_t cipher_index(input logic [7:0] ch);
		ltr_idx_t r;
		r.ok = 1'b0;
		r.idx = '0;
		if (ch inside {[UC_A:UC_Z]}) begin
			r.ok = 1'b1;
			r.idx = 5'(ch - UC_A);
			if (r.idx == IDX_J)
				r.idx = IDX_I;
		end
		return r;
	endfunction

	// cell number to row and column, cell below 25
	function automatic rc_t pos_to_rc(input logic [4:0] pos);
		rc_t r;
		if (pos >= 5'd20) begin
			r.row = 3'd4;
			r.col = 3'(pos - 5'd20);
		end else if (pos >= 5'd15) begin
			r.row = 3'd3;
			r.col = 3'(pos - 5'd15);
		end else if (pos >= 5'd10) begin
			r.row = 3'd2;
			r.col = 3'(pos - 5'd10);
		end else if (pos >= 5'd5) begin
			r.row = 3'd1;
			r.col = 3'(pos - 5'd5);
		end else begin
			r.row = 3'd0;
			r.col = 3'(pos);
		end
		return r;
	endfunction

	function automatic logic [2:0] dec_wrap(input logic [2:0] v);
		return (v == 3'd0) ? 3'(SQ_DIM - 1) : v - 3'd1;
	endfunction

	function automatic logic [4:0] rc_to_cell(input rc_t rc);
		return {rc.row, 2'b00} + 5'(rc.row) + 5'(rc.col);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pfd_ram.sv =====
`default_nettype none

// one write port, two registered read ports
module pfd_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pfd_corner.sv =====
`default_nettype none

// Playfair decrypt rule on two cell numbers: gives the two cells to read
module pfd_corner (
	input  wire logic [4:0] pos_a,
	input  wire logic [4:0] pos_b,
	output logic      [4:0] cell_a,
	output logic      [4:0] cell_b
);

	pfd_pkg::rc_t rc_a, rc_b, out_a, out_b;

	always_comb begin
		rc_a = pfd_pkg::pos_to_rc(pos_a);
		rc_b = pfd_pkg::pos_to_rc(pos_b);
		if (rc_a.row == rc_b.row) begin
			out_a = '{row: rc_a.row, col: pfd_pkg::dec_wrap(rc_a.col)};
			out_b = '{row: rc_b.row, col: pfd_pkg::dec_wrap(rc_b.col)};
		end else if (rc_a.col == rc_b.col) begin
			out_a = '{row: pfd_pkg::dec_wrap(rc_a.row), col: rc_a.col};
			out_b = '{row: pfd_pkg::dec_wrap(rc_b.row), col: rc_b.col};
		end else begin
			out_a = '{row: rc_a.row, col: rc_b.col};
			out_b = '{row: rc_b.row, col: rc_a.col};
		end
		cell_a = pfd_pkg::rc_to_cell(out_a);
		cell_b = pfd_pkg::rc_to_cell(out_b);
	end

endmodule

`default_nettype wire

// ===== hw/rtl/playfair_digraph_decrypt.sv =====
`default_nettype none

// Playfair 5x5 digraph decryptor. A request is taken when start is high and
// busy is low; its result appears on plain_a, plain_b and bad_letter for one
// cycle with done high, and the receiver cannot stall it. Clear and key-letter
// requests give their result in the next cycle. Key done walks the 26
// letters one per cycle, then raises done. A decrypt pair reads the
// letter-position memory, then the key-square memory, each read registered;
// a pair with a letter outside the square is echoed with bad_letter set in
// the next cycle. Decrypting before the square is full may read cells that
// were never written.
module playfair_digraph_decrypt (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] letter_a,
	input  wire logic [7:0] letter_b,
	output logic            done,
	output logic      [7:0] plain_a,
	output logic      [7:0] plain_b,
	output logic            bad_letter
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_FILL = 2'd1;
	localparam logic [1:0] S_POS  = 2'd2;
	localparam logic [1:0] S_SQ   = 2'd3;

	logic [1:0]  state_q;
	logic [25:0] used_q;
	logic [4:0]  fill_q;
	logic [4:0]  fill_idx_q;
	logic        done_q, bad_q;
	logic [7:0]  plain_a_q, plain_b_q;

	logic        accept;
	pfd_pkg::ltr_idx_t key_li, ca_li, cb_li;
	logic        pair_ok;
	logic        place_req, place_do;
	logic [4:0]  place_idx;
	logic [4:0]  pos_a, pos_b, cell_a, cell_b, sq_a, sq_b;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	always_comb begin
		key_li  = pfd_pkg::key_index(letter_a);
		ca_li   = pfd_pkg::cipher_index(letter_a);
		cb_li   = pfd_pkg::cipher_index(letter_b);
		pair_ok = ca_li.ok && cb_li.ok && used_q[ca_li.idx] && used_q[cb_li.idx];
	end

	// at most one letter placed per cycle, from a key request or the key-done walk
	always_comb begin
		place_req = 1'b0;
		place_idx = key_li.idx;
		if (state_q == S_FILL) begin
			place_req = (fill_idx_q != pfd_pkg::IDX_J);
			place_idx = fill_idx_q;
		end else if (accept && opcode == pfd_pkg::OP_KEY) begin
			place_req = key_li.ok;
		end
		place_do = place_req && !used_q[place_idx] && (fill_q < pfd_pkg::CELL_MAX);
	end

	pfd_ram #(.DEPTH(pfd_pkg::NUM_LETTERS), .WIDTH(5)) u_pos_ram (
		.clk     (clk),
		.we      (place_do),
		.waddr   (place_idx),
		.wdata   (fill_q),
		.raddr_a (ca_li.idx),
		.raddr_b (cb_li.idx),
		.rdata_a (pos_a),
		.rdata_b (pos_b)
	);

	pfd_corner u_corner (
		.pos_a  (pos_a),
		.pos_b  (pos_b),
		.cell_a (cell_a),
		.cell_b (cell_b)
	);

	pfd_ram #(.DEPTH(pfd_pkg::NUM_CELLS), .WIDTH(5)) u_sq_ram (
		.clk     (clk),
		.we      (place_do),
		.waddr   (fill_q),
		.wdata   (place_idx),
		.raddr_a (cell_a),
		.raddr_b (cell_b),
		.rdata_a (sq_a),
		.rdata_b (sq_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			fill_q     <= '0;
			fill_idx_q <= '0;
			done_q     <= 1'b0;
			bad_q      <= 1'b0;
			plain_a_q  <= '0;
			plain_b_q  <= '0;
		end else begin
			done_q    <= 1'b0;
			bad_q     <= 1'b0;
			plain_a_q <= '0;
			plain_b_q <= '0;
			if (place_do) begin
				used_q[place_idx] <= 1'b1;
				fill_q            <= fill_q + 5'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (opcode)
							pfd_pkg::OP_CLEAR: begin
								used_q <= '0;
								fill_q <= '0;
								done_q <= 1'b1;
							end
							pfd_pkg::OP_KEY: begin
								done_q <= 1'b1;
							end
							pfd_pkg::OP_KEY_DONE: begin
								fill_idx_q <= '0;
								state_q    <= S_FILL;
							end
							default: begin
								if (pair_ok) begin
									state_q <= S_POS;
								end else begin
									done_q    <= 1'b1;
									bad_q     <= 1'b1;
									plain_a_q <= letter_a;
									plain_b_q <= letter_b;
								end
							end
						endcase
					end
				end
				S_FILL: begin
					if (fill_idx_q == pfd_pkg::IDX_LAST) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						fill_idx_q <= fill_idx_q + 5'd1;
					end
				end
				S_POS: begin
					state_q <= S_SQ;
				end
				S_SQ: begin
					done_q    <= 1'b1;
					plain_a_q <= 8'(sq_a) + pfd_pkg::UC_A;
					plain_b_q <= 8'(sq_b) + pfd_pkg::UC_A;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign bad_letter = bad_q;
	assign plain_a    = plain_a_q;
	assign plain_b    = plain_b_q;

`include "playfair_digraph_decrypt_macros.svh"

	`PFD_ASSERT_SAME(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE, "result while busy")
	`PFD_ASSERT_SAME(a_bad_done, clk, arst_n, bad_q, done_q, "bad flag without result")
	`PFD_ASSERT_SAME(a_fill_range, clk, arst_n, 1'b1, fill_q <= pfd_pkg::CELL_MAX, "fill past square")
	`PFD_ASSERT_NEXT(a_pos_to_sq, clk, arst_n, state_q == S_POS, state_q == S_SQ, "lookup skipped")
	`PFD_ASSERT_NEXT(a_short_op, clk, arst_n, accept && (opcode == pfd_pkg::OP_CLEAR || opcode == pfd_pkg::OP_KEY), done_q, "key request gave no result")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
module tb_top;
	import pfd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int REQUEST_GOAL = 550;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [7:0] pa;
		logic [7:0] pb;
		logic       bad;
	} plain_pair_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] opcode;
	logic [7:0] letter_a;
	logic [7:0] letter_b;
	logic       done;
	logic [7:0] plain_a;
	logic [7:0] plain_b;
	logic       bad_letter;

	playfair_digraph_decrypt u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.letter_a   (letter_a),
		.letter_b   (letter_b),
		.done       (done),
		.plain_a    (plain_a),
		.plain_b    (plain_b),
		.bad_letter (bad_letter)
	);

	// mirror of the key square and letter map
	logic [4:0]  sq_letter [NUM_CELLS];
	bit          sq_written [NUM_CELLS];
	logic [4:0]  letter_cell [NUM_LETTERS];
	bit          letter_placed [NUM_LETTERS];
	int          cells_filled;

	plain_pair_t expected_plain [$];
	int          mismatches = 0;
	int          cycle_count = 0;
	int          requests_sent = 0;
	bit          no_gaps = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	function automatic void clear_letters();
		for (int i = 0; i < NUM_LETTERS; i++) begin
			letter_cell[i] = '0;
			letter_placed[i] = 1'b0;
		end
		cells_filled = 0;
	endfunction

	function automatic void place_key_letter(input logic [4:0] idx);
		if (letter_placed[idx] || cells_filled >= NUM_CELLS)
			return;
		sq_letter[cells_filled] = idx;
		sq_written[cells_filled] = 1'b1;
		letter_cell[idx] = 5'(cells_filled);
		letter_placed[idx] = 1'b1;
		cells_filled++;
	endfunction

	function automatic bit cipher_slot(input logic [7:0] ch, output logic [4:0] idx);
		idx = 5'(ch - UC_A);
		if (ch < UC_A || ch > UC_Z)
			return 1'b0;
		if (idx == IDX_J)
			idx = IDX_I;
		return letter_placed[idx];
	endfunction

	// cells holding the plaintext of a pair; 0 when a letter is off the square
	function automatic bit pair_cells(input logic [7:0] a, input logic [7:0] b,
			output int ca, output int cb);
		logic [4:0] ia;
		logic [4:0] ib;
		int r1, c1, r2, c2;
		ca = 0;
		cb = 0;
		if (!cipher_slot(a, ia) || !cipher_slot(b, ib))
			return 1'b0;
		r1 = int'(letter_cell[ia]) / SQ_DIM;
		c1 = int'(letter_cell[ia]) % SQ_DIM;
		r2 = int'(letter_cell[ib]) / SQ_DIM;
		c2 = int'(letter_cell[ib]) % SQ_DIM;
		if (r1 == r2) begin
			ca = r1 * SQ_DIM + (c1 + SQ_DIM - 1) % SQ_DIM;
			cb = r2 * SQ_DIM + (c2 + SQ_DIM - 1) % SQ_DIM;
		end else if (c1 == c2) begin
			ca = ((r1 + SQ_DIM - 1) % SQ_DIM) * SQ_DIM + c1;
			cb = ((r2 + SQ_DIM - 1) % SQ_DIM) * SQ_DIM + c2;
		end else begin
			ca = r1 * SQ_DIM + c2;
			cb = r2 * SQ_DIM + c1;
		end
		return 1'b1;
	endfunction

	// a pair must never read a cell that was not written since reset
	function automatic bit pair_reads_written(input logic [7:0] a, input logic [7:0] b);
		int ca, cb;
		if (!pair_cells(a, b, ca, cb))
			return 1'b1;
		return sq_written[ca] && sq_written[cb];
	endfunction

	function automatic plain_pair_t decrypt_step(input logic [1:0] op,
			input logic [7:0] a, input logic [7:0] b);
		plain_pair_t res;
		logic [7:0] up;
		logic [4:0] idx;
		int ca, cb;
		res = '0;
		case (op)
			OP_CLEAR: begin
				clear_letters();
			end
			OP_KEY: begin
				up = a;
				if (a >= LC_A && a <= LC_Z)
					up = a - CASE_GAP;
				if (up >= UC_A && up <= UC_Z) begin
					idx = 5'(up - UC_A);
					if (idx == IDX_J)
						idx = IDX_I;
					place_key_letter(idx);
				end
			end
			OP_KEY_DONE: begin
				for (int i = 0; i < NUM_LETTERS; i++)
					if (5'(i) != IDX_J)
						place_key_letter(5'(i));
			end
			default: begin
				if (pair_cells(a, b, ca, cb)) begin
					res.pa = UC_A + 8'(sq_letter[ca]);
					res.pb = UC_A + 8'(sq_letter[cb]);
				end else begin
					res.pa = a;
					res.pb = b;
					res.bad = 1'b1;
				end
			end
		endcase
		return res;
	endfunction

	// entered and left at a falling edge
	task automatic send_request(input logic [1:0] op, input logic [7:0] a,
			input logic [7:0] b);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			start = 1'b0;
			opcode = 2'($urandom);
			letter_a = 8'($urandom);
			letter_b = 8'($urandom);
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		opcode = op;
		letter_a = a;
		letter_b = b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_plain.push_back(decrypt_step(op, a, b));
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic send_pair(input logic [7:0] a, input logic [7:0] b);
		if (pair_reads_written(a, b))
			send_request(OP_DECRYPT, a, b);
	endtask

	always @(posedge clk) begin
		plain_pair_t want;
		if (arst_n && done) begin
			if (expected_plain.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("tb_top: result with nothing pending: %h %h %b",
						plain_a, plain_b, bad_letter);
			end else begin
				want = expected_plain.pop_front();
				if (plain_a !== want.pa || plain_b !== want.pb || bad_letter !== want.bad) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("tb_top: mismatch exp %h %h %b got %h %h %b",
							want.pa, want.pb, want.bad, plain_a, plain_b, bad_letter);
				end
			end
		end
	end

	function automatic logic [7:0] key_char();
		int r;
		r = $urandom_range(0, 9);
		if (r <= 5)
			return UC_A + 8'($urandom_range(0, 25));
		if (r <= 7)
			return LC_A + 8'($urandom_range(0, 25));
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] cipher_char();
		int r;
		logic [7:0] ch;
		r = $urandom_range(0, 9);
		if (r == 9)
			return 8'($urandom);
		if (r == 8 || cells_filled == 0)
			return UC_A + 8'($urandom_range(0, 25));
		ch = UC_A + 8'(sq_letter[$urandom_range(0, cells_filled - 1)]);
		if (ch == UC_A + 8'(IDX_I) && $urandom_range(0, 1) == 1)
			ch = UC_A + 8'(IDX_J);
		return ch;
	endfunction

	task automatic test_empty_square();
		send_pair("A", "B");
		send_pair(8'h00, 8'hFF);
		send_request(OP_KEY_DONE, 8'h00, 8'h00);
		send_pair("Q", "C");
	endtask

	// lower case, J folding, repeats, non-letters, and a full square
	task automatic test_key_entry();
		send_request(OP_CLEAR, 8'hFF, 8'hFF);
		send_request(OP_KEY, "p", 8'h00);
		send_request(OP_KEY, "L", 8'hFF);
		send_request(OP_KEY, "Y", 8'h00);
		send_request(OP_KEY, "@", 8'h00);
		send_request(OP_KEY, "J", 8'h00);
		send_request(OP_KEY, "i", 8'h00);
		send_request(OP_KEY, "{", 8'h00);
		send_request(OP_KEY, "F", 8'h00);
		send_request(OP_KEY, 8'hFF, 8'h00);
		send_request(OP_KEY_DONE, 8'h00, 8'h00);
		send_request(OP_KEY_DONE, 8'hFF, 8'hFF);
		send_request(OP_KEY, "Q", 8'h00);
	endtask

	task automatic test_decrypt_rules();
		send_pair("L", "F");
		send_pair("B", "Q");
		send_pair("P", "Z");
		send_pair("J", "Y");
		send_pair("Q", "Q");
		send_pair("a", "B");
		send_pair("A", 8'hFF);
	endtask

	// after a clear the old cells still hold the previous square
	task automatic test_clear_stale();
		send_request(OP_CLEAR, 8'h00, 8'h00);
		send_request(OP_KEY, "Z", 8'h00);
		send_pair("Z", "Z");
		send_pair("Z", "A");
	endtask

	task automatic test_random_sessions();
		int n_keys;
		int n_pairs;
		logic [1:0] op;
		while (requests_sent < REQUEST_GOAL) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 7) != 0)
				send_request(OP_CLEAR, 8'($urandom), 8'($urandom));
			n_keys = $urandom_range(0, 30);
			repeat (n_keys)
				send_request(OP_KEY, key_char(), 8'($urandom));
			if ($urandom_range(0, 5) != 0)
				send_request(OP_KEY_DONE, 8'($urandom), 8'($urandom));
			n_pairs = $urandom_range(4, 24);
			repeat (n_pairs)
				send_pair(cipher_char(), cipher_char());
			if ($urandom_range(0, 3) == 0) begin
				op = 2'($urandom);
				if (op == OP_DECRYPT)
					send_pair(8'($urandom), 8'($urandom));
				else
					send_request(op, 8'($urandom), 8'($urandom));
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_CLEAR;
		letter_a = '0;
		letter_b = '0;
		for (int i = 0; i < NUM_CELLS; i++) begin
			sq_letter[i] = '0;
			sq_written[i] = 1'b0;
		end
		clear_letters();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_square();
		test_key_entry();
		test_decrypt_rules();
		test_clear_stale();
		test_random_sessions();

		start = 1'b0;
		while (expected_plain.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
